// ===== hdl/cab_pkg.sv =====
// ----------------------------------------------------------------------------
// cab_pkg
// Shared constants, register indexes and helper functions for the
// coverage alpha blend pipeline.
// ----------------------------------------------------------------------------
package cab_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIXEL_W    = 32;
  localparam int COORD_W    = 16;
  localparam int SURF_W     = 15;
  localparam int SHIFT_W    = 5;
  localparam int PROD_W     = 2 * CHAN_W;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  localparam logic [PIXEL_W-1:0] FILL_COLOR_RST  = 32'd0;
  localparam logic [SHIFT_W-1:0] RED_SHIFT_RST   = 5'd16;
  localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RST = 5'd8;
  localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RST  = 5'd0;
  localparam logic [SHIFT_W-1:0] ALPHA_SHIFT_RST = 5'd24;
  localparam logic [SURF_W-1:0]  SURF_SIZE_RST   = 15'd0;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FILL_COLOR     = 3'd0,
    REG_RED_SHIFT      = 3'd1,
    REG_GREEN_SHIFT    = 3'd2,
    REG_BLUE_SHIFT     = 3'd3,
    REG_ALPHA_SHIFT    = 3'd4,
    REG_SURFACE_WIDTH  = 3'd5,
    REG_SURFACE_HEIGHT = 3'd6
  } cab_reg_t;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PROD_W-1:0] prod_t;

  // (x + 127) / 255 via (y * 257) >> 16 with y = x + 128
  function automatic chan_t div255r(input prod_t x);
    logic [PROD_W:0]     y;
    logic [PROD_W+8:0]   t;
    begin
      y = {1'b0, x} + (PROD_W+1)'(128);
      t = {y, 8'd0} + {8'd0, y};
      return t[PROD_W+7:PROD_W];
    end
  endfunction

  function automatic chan_t sat8(input logic [CHAN_W:0] v);
    begin
      return v[CHAN_W] ? CHAN_MAX : v[CHAN_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/coverage_alpha_blend.sv =====
// ----------------------------------------------------------------------------
// coverage_alpha_blend
// Five-stage pipeline that blends a fill color at glyph coverage strength
// onto one destination pixel, with clipping against the surface size.
// ----------------------------------------------------------------------------
// Data path: an input transaction passes the stage 1 to 4 registers and then
// the output register. Throughput: one transaction per cycle while out_ready
// is high; each stage advances when empty or when the stage after it
// advances, so bubbles are filled during a stall.
// Reset: synchronous active-low; clears all valid bits and loads register
// defaults (red 16, green 8, blue 0, alpha 24, color and surface size 0).
module coverage_alpha_blend (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cab_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [cab_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cab_pkg::CHAN_W-1:0]         in_coverage,
  input  logic [cab_pkg::PIXEL_W-1:0]        in_dest_pixel,
  input  logic signed [cab_pkg::COORD_W-1:0] in_pixel_x,
  input  logic signed [cab_pkg::COORD_W-1:0] in_pixel_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cab_pkg::PIXEL_W-1:0]        out_new_pixel,
  output logic                               out_write_enable
);
  import cab_pkg::*;

  // configuration
  logic [PIXEL_W-1:0] fill_color_r;
  logic [SHIFT_W-1:0] red_shift_r, green_shift_r, blue_shift_r, alpha_shift_r;
  logic [SURF_W-1:0]  surface_width_r, surface_height_r;

  // stage enables
  logic en1, en2, en3, en4, en5;

  // stage 1
  logic               v1_r;
  prod_t              p1_r;
  logic               inside1_r;
  logic [PIXEL_W-1:0] d1_r;
  logic [3*CHAN_W-1:0] src1_r;
  logic               inside1_nxt;
  chan_t              opacity;

  // stage 2
  logic               v2_r;
  chan_t              a2_r, inv2_r;
  logic               we2_r;
  logic [PIXEL_W-1:0] d2_r;
  logic [3*CHAN_W-1:0] src2_r;
  chan_t              dch2_r [4];
  chan_t              a2_nxt;
  chan_t              dch2_nxt [4];
  logic [PIXEL_W-1:0] sh_red, sh_green, sh_blue, sh_alpha;

  // stage 3
  logic               v3_r;
  chan_t              a3_r;
  logic               we3_r;
  logic [PIXEL_W-1:0] d3_r;
  prod_t              ps3_r [3];
  prod_t              pd3_r [4];

  // stage 4
  logic               v4_r;
  logic               we4_r;
  logic [PIXEL_W-1:0] d4_r;
  chan_t              ch4_r [4];
  chan_t              ch4_nxt [4];

  // output stage
  logic               out_valid_r;
  logic [PIXEL_W-1:0] out_pixel_r;
  logic               out_we_r;
  logic [PIXEL_W-1:0] pix_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_color_r     <= FILL_COLOR_RST;
      red_shift_r      <= RED_SHIFT_RST;
      green_shift_r    <= GREEN_SHIFT_RST;
      blue_shift_r     <= BLUE_SHIFT_RST;
      alpha_shift_r    <= ALPHA_SHIFT_RST;
      surface_width_r  <= SURF_SIZE_RST;
      surface_height_r <= SURF_SIZE_RST;
    end else if (cfg_we) begin
      case (cab_reg_t'(cfg_index))
        REG_FILL_COLOR:     fill_color_r     <= cfg_wdata[PIXEL_W-1:0];
        REG_RED_SHIFT:      red_shift_r      <= cfg_wdata[SHIFT_W-1:0];
        REG_GREEN_SHIFT:    green_shift_r    <= cfg_wdata[SHIFT_W-1:0];
        REG_BLUE_SHIFT:     blue_shift_r     <= cfg_wdata[SHIFT_W-1:0];
        REG_ALPHA_SHIFT:    alpha_shift_r    <= cfg_wdata[SHIFT_W-1:0];
        REG_SURFACE_WIDTH:  surface_width_r  <= cfg_wdata[SURF_W-1:0];
        REG_SURFACE_HEIGHT: surface_height_r <= cfg_wdata[SURF_W-1:0];
        default: ;
      endcase
    end
  end

  assign en5      = !out_valid_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // stage 1: coverage times opacity, clip test
  assign opacity     = CHAN_MAX - fill_color_r[CHAN_W-1:0];
  assign inside1_nxt = !in_pixel_x[COORD_W-1] && !in_pixel_y[COORD_W-1] &&
                       (in_pixel_x[SURF_W-1:0] < surface_width_r) &&
                       (in_pixel_y[SURF_W-1:0] < surface_height_r);

  // stage 2: effective alpha, destination channel extract
  assign a2_nxt   = div255r(p1_r);
  assign sh_red   = d1_r >> red_shift_r;
  assign sh_green = d1_r >> green_shift_r;
  assign sh_blue  = d1_r >> blue_shift_r;
  assign sh_alpha = d1_r >> alpha_shift_r;
  assign dch2_nxt[0] = sh_red[CHAN_W-1:0];
  assign dch2_nxt[1] = sh_green[CHAN_W-1:0];
  assign dch2_nxt[2] = sh_blue[CHAN_W-1:0];
  assign dch2_nxt[3] = sh_alpha[CHAN_W-1:0];

  // stage 4: rounded terms, sum, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch4_nxt[i] = sat8({1'b0, div255r(ps3_r[i])} + {1'b0, div255r(pd3_r[i])});
    end
    ch4_nxt[3] = sat8({1'b0, a3_r} + {1'b0, div255r(pd3_r[3])});
  end

  // output stage: place channels
  assign pix_nxt = ({{(PIXEL_W-CHAN_W){1'b0}}, ch4_r[0]} << red_shift_r) |
                   ({{(PIXEL_W-CHAN_W){1'b0}}, ch4_r[1]} << green_shift_r) |
                   ({{(PIXEL_W-CHAN_W){1'b0}}, ch4_r[2]} << blue_shift_r) |
                   ({{(PIXEL_W-CHAN_W){1'b0}}, ch4_r[3]} << alpha_shift_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r        <= in_valid;
      if (en2) v2_r        <= v1_r;
      if (en3) v3_r        <= v2_r;
      if (en4) v4_r        <= v3_r;
      if (en5) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_r      <= prod_t'(in_coverage) * prod_t'(opacity);
      inside1_r <= inside1_nxt;
      d1_r      <= in_dest_pixel;
      src1_r    <= fill_color_r[PIXEL_W-1:CHAN_W];
    end
    if (en2) begin
      a2_r   <= a2_nxt;
      inv2_r <= CHAN_MAX - a2_nxt;
      we2_r  <= inside1_r && (a2_nxt != '0);
      d2_r   <= d1_r;
      src2_r <= src1_r;
      for (int i = 0; i < 4; i++) begin
        dch2_r[i] <= dch2_nxt[i];
      end
    end
    if (en3) begin
      a3_r     <= a2_r;
      we3_r    <= we2_r;
      d3_r     <= d2_r;
      ps3_r[0] <= prod_t'(src2_r[3*CHAN_W-1:2*CHAN_W]) * prod_t'(a2_r);
      ps3_r[1] <= prod_t'(src2_r[2*CHAN_W-1:CHAN_W]) * prod_t'(a2_r);
      ps3_r[2] <= prod_t'(src2_r[CHAN_W-1:0]) * prod_t'(a2_r);
      for (int i = 0; i < 4; i++) begin
        pd3_r[i] <= prod_t'(dch2_r[i]) * prod_t'(inv2_r);
      end
    end
    if (en4) begin
      we4_r <= we3_r;
      d4_r  <= d3_r;
      for (int i = 0; i < 4; i++) begin
        ch4_r[i] <= ch4_nxt[i];
      end
    end
    if (en5) begin
      out_we_r    <= we4_r;
      out_pixel_r <= we4_r ? pix_nxt : d4_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_pixel    = out_pixel_r;
  assign out_write_enable = out_we_r;

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !v1_r && !v4_r)
    else $error("pipeline valid bits not cleared by reset");

  a_zero_cov : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_coverage == '0) |=> v1_r && (p1_r == '0))
    else $error("zero coverage gave nonzero alpha product");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !en4 |=> v4_r && $stable(we4_r) && $stable(d4_r))
    else $error("stage 4 changed while stalled");

  a_no_write_zero_alpha : assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && (a2_r == '0) |-> !we2_r)
    else $error("write flagged with zero alpha");

endmodule
